// ----- src/mtd_pkg.sv -----
// Shared types and constants for the Manchester edge-timing decoder.
package mtd_pkg;

	// Counted preamble edges before the period is taken.
	localparam int PREAMBLE_EDGES = 7;
	localparam int CNT_W          = $clog2(PREAMBLE_EDGES + 1);

	// Period = span / PERIOD_DIV, saturated to 16 bits.
	localparam int PERIOD_DIV = 2 * PREAMBLE_EDGES;
	localparam int PERIOD_W   = 16;
	localparam logic [31:0] SAT_LIM = 32'(PERIOD_DIV * 65536);

	// Reciprocal multiply: exact for every span below SAT_LIM.
	localparam int SPAN_W   = $clog2(PERIOD_DIV * 65536);
	localparam int RECIP_SH = SPAN_W + $clog2(PERIOD_DIV);
	localparam int RECIP_W  = RECIP_SH - $clog2(PERIOD_DIV) + 1;
	localparam logic [63:0] RECIP =
		((64'd1 << RECIP_SH) + 64'(PERIOD_DIV) - 64'd1) / 64'(PERIOD_DIV);

	typedef enum logic [2:0] {
		ST_INITIAL = 3'd0,
		ST_OUT0    = 3'd1,
		ST_WAITS   = 3'd2,
		ST_OUT1    = 3'd3,
		ST_WAITL   = 3'd4
	} mtd_state_t;

	// Gap classification against the current period.
	typedef struct packed {
		logic reject;
		logic pause;
		logic very_long;
		logic long_gap;
	} mtd_gap_t;

	// One result beat, bit_valid in the lowest bit.
	typedef struct packed {
		logic [PERIOD_W-1:0] bit_period_ms;
		logic                pause_reset;
		logic                preamble_done;
		logic                bit_value;
		logic                bit_valid;
	} mtd_result_t;

endpackage

// ----- src/manchester_edge_timing_decoder.sv -----
// Top level of the Manchester edge-timing decoder: handshake and pipeline registers.
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_*     | in  | edge_time_ms[31:0], line_level, receive_enabled  | in_preamble
//  m_*     | out | bit_valid, bit_value, preamble_done,             | -
//          |     | pause_reset, bit_period_ms[15:0]                 |
//
// One edge beat is taken per clock while m_tready does not stall; its result beat
// passes through the input register, then the result register. The decode state
// updates as the beat moves from the input register into the result register,
// which sets the one-beat-per-cycle rate. arst_n clears the decode state, the
// timing registers and both valid flags. A stall on m_tready holds the result
// and, through the input register, back-pressures s_tready.
module manchester_edge_timing_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // edge_time_ms[31:0], line_level, receive_enabled, zero pad
	input  logic        s_tuser,  // in_preamble
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // bit_valid, bit_value, preamble_done, pause_reset,
	                              // bit_period_ms[15:0], zero pad
);
	import mtd_pkg::*;

	logic        valid_s1;
	logic [31:0] time_s1;
	logic        level_s1;
	logic        enable_s1;
	logic        preamble_s1;
	logic        valid_s2;
	mtd_result_t result_s2;
	mtd_result_t result_c;
	logic        s2_free;
	logic        fire;

	// Advance the result register whenever it is empty or being drained.
	assign s2_free  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			time_s1     <= s_tdata[31:0];
			level_s1    <= s_tdata[32];
			enable_s1   <= s_tdata[33];
			preamble_s1 <= s_tuser;
		end
	end

	// Decode one edge against the stored timing state.
	mtd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.edge_time_ms    (time_s1),
		.line_level      (level_s1),
		.receive_enabled (enable_s1),
		.in_preamble     (preamble_s1),
		.result          (result_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, result_s2};

	// A decoded bit and a finished preamble never share one beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result_s2.bit_valid && result_s2.preamble_done))
		else $error("bit and preamble_done in the same beat");

	// A bit value of one only comes with a decoded bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !result_s2.bit_valid) |-> !result_s2.bit_value)
		else $error("bit_value set without bit_valid");

	// A processed edge always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("processed edge lost");

	// An empty input register never back-pressures.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("ready low with empty input register");

endmodule

// ----- src/mtd_gap_class.sv -----
// Classifies an edge gap against multiples of the measured period.
module mtd_gap_class (
	input  logic [31:0]                   gap,
	input  logic [mtd_pkg::PERIOD_W-1:0]  period,
	output mtd_pkg::mtd_gap_t             cls
);
	import mtd_pkg::*;

	logic [32:0] gap2;
	logic [32:0] p1;
	logic [32:0] p3;
	logic [32:0] p5;
	logic [32:0] p25;

	// Compare doubled gap against integer multiples of the period.
	assign gap2 = {gap, 1'b0};
	assign p1   = {17'd0, period};
	assign p3   = (p1 << 1) + p1;
	assign p5   = (p1 << 2) + p1;
	assign p25  = (p1 << 4) + (p1 << 3) + p1;

	assign cls.reject    = gap2 < p1;
	assign cls.pause     = gap2 > p25;
	assign cls.very_long = gap2 > p5;
	assign cls.long_gap  = gap2 >= p3;

endmodule

// ----- src/mtd_period_calc.sv -----
// Turns a preamble span into a saturated bit period by reciprocal multiply.
module mtd_period_calc (
	input  logic [31:0]                  span,
	output logic [mtd_pkg::PERIOD_W-1:0] period
);
	import mtd_pkg::*;

	logic                        sat;
	logic [SPAN_W+RECIP_W-1:0]   prod;

	assign sat  = span >= SAT_LIM;
	assign prod = {{RECIP_W{1'b0}}, span[SPAN_W-1:0]} *
	              {{SPAN_W{1'b0}}, RECIP[RECIP_W-1:0]};

	assign period = sat ? {PERIOD_W{1'b1}} : prod[RECIP_SH +: PERIOD_W];

endmodule

// ----- src/mtd_core.sv -----
// Decoder state, preamble measurement and Manchester state machine.
module mtd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [31:0]          edge_time_ms,
	input  logic                 line_level,
	input  logic                 receive_enabled,
	input  logic                 in_preamble,
	output mtd_pkg::mtd_result_t result
);
	import mtd_pkg::*;

	mtd_state_t          state_q;
	mtd_state_t          state_d;
	mtd_state_t          state_eff;
	logic [31:0]         last_edge_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_d;
	logic [31:0]         first_time_q;
	logic [31:0]         first_time_d;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] period_d;
	logic [PERIOD_W-1:0] period_new;
	mtd_gap_t            cls;
	logic                live;
	logic                pre_skip;
	logic                pre_full;

	mtd_gap_class u_gap (
		.gap    (edge_time_ms - last_edge_q),
		.period (period_q),
		.cls    (cls)
	);

	mtd_period_calc u_period (
		.span   (edge_time_ms - first_time_q),
		.period (period_new)
	);

	assign live      = receive_enabled && !cls.reject;
	assign pre_skip  = !line_level && (cnt_q == '0);
	assign pre_full  = !(cnt_q < CNT_W'(PREAMBLE_EDGES));
	// A very long gap drops the machine back to initial first.
	assign state_eff = cls.very_long ? ST_INITIAL : state_q;

	// Next state
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		first_time_d = first_time_q;
		period_d     = period_q;
		if (live) begin
			if (in_preamble) begin
				if (!pre_skip) begin
					if (!pre_full) begin
						if (cnt_q == '0) begin
							first_time_d = edge_time_ms;
						end
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						period_d = period_new;
						cnt_d    = '0;
						state_d  = ST_INITIAL;
					end
				end
			end else begin
				case (state_eff)
					ST_OUT0: begin
						if (!cls.long_gap) begin
							state_d = ST_WAITS;
						end else if (!cls.very_long) begin
							state_d = ST_OUT1;
						end else begin
							state_d = ST_OUT0;
						end
					end
					ST_WAITS: state_d = ST_OUT0;
					ST_OUT1: begin
						if (!cls.long_gap) begin
							state_d = ST_WAITL;
						end else begin
							state_d = ST_OUT0;
						end
					end
					ST_WAITL: state_d = ST_OUT1;
					default:  state_d = ST_OUT0;
				endcase
			end
		end
	end

	// Outputs
	always_comb begin
		result               = '0;
		result.bit_period_ms = period_d;
		if (live) begin
			result.pause_reset = cls.pause;
			if (in_preamble) begin
				result.preamble_done = !pre_skip && pre_full;
			end else begin
				case (state_eff)
					ST_OUT0: begin
						result.bit_valid = cls.long_gap && !cls.very_long;
						result.bit_value = cls.long_gap && !cls.very_long;
					end
					ST_WAITS: result.bit_valid = 1'b1;
					ST_OUT1:  result.bit_valid = cls.long_gap;
					ST_WAITL: begin
						result.bit_valid = 1'b1;
						result.bit_value = 1'b1;
					end
					default:  result.bit_valid = 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INITIAL;
			last_edge_q  <= '0;
			cnt_q        <= '0;
			first_time_q <= '0;
			period_q     <= '0;
		end else if (fire) begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			first_time_q <= first_time_d;
			period_q     <= period_d;
			if (receive_enabled) begin
				last_edge_q <= edge_time_ms;
			end
		end
	end

endmodule

// ----- tb/mtd_decode_checker.sv -----
// Edge-decoder checker: predicts each result beat from the accepted edge beats and compares.
module mtd_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          errors,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import mtd_pkg::*;

	typedef enum logic [1:0] {
		GAP_SHORT,
		GAP_LONG,
		GAP_VLONG
	} gap_class_t;

	// Shadow of the decoder state.
	mtd_state_t          dec_state;
	logic [31:0]         prev_time;
	logic [CNT_W-1:0]    pre_count;
	logic [31:0]         first_time;
	logic [PERIOD_W-1:0] period;

	mtd_result_t due_results[$];

	initial errors = 0;

	// Advance the shadow state by one edge and return the result beat it causes.
	function automatic mtd_result_t decode_edge(input logic [31:0] t, input logic lvl,
			input logic en, input logic pre);
		mtd_result_t r;
		logic [33:0] gap2;
		logic [33:0] p;
		logic [31:0] span;
		logic [31:0] quo;
		gap_class_t  cls;
		r = '0;
		if (en) begin
			gap2 = {1'b0, t - prev_time, 1'b0};
			p = 34'(period);
			prev_time = t;
			if (gap2 >= p) begin
				if (gap2 > p * 34'd25)
					r.pause_reset = 1'b1;
				if (pre) begin
					// a low level cannot open the preamble count
					if (!(lvl == 1'b0 && pre_count == 0)) begin
						if (pre_count < PREAMBLE_EDGES) begin
							if (pre_count == 0)
								first_time = t;
							pre_count = pre_count + 1'b1;
						end else begin
							span = t - first_time;
							quo = span / 32'(2 * PREAMBLE_EDGES);
							period = (quo > 32'd65535) ? 16'hFFFF : quo[15:0];
							pre_count = '0;
							dec_state = ST_INITIAL;
							r.preamble_done = 1'b1;
						end
					end
				end else begin
					if (gap2 > p * 34'd5) begin
						cls = GAP_VLONG;
						dec_state = ST_INITIAL;
					end else if (gap2 >= p * 34'd3) begin
						cls = GAP_LONG;
					end else begin
						cls = GAP_SHORT;
					end
					case (dec_state)
						ST_OUT0: begin
							if (cls == GAP_SHORT) begin
								dec_state = ST_WAITS;
							end else if (cls == GAP_LONG) begin
								dec_state = ST_OUT1;
								r.bit_valid = 1'b1;
								r.bit_value = 1'b1;
							end
						end
						ST_WAITS: begin
							dec_state = ST_OUT0;
							r.bit_valid = 1'b1;
						end
						ST_OUT1: begin
							if (cls == GAP_SHORT) begin
								dec_state = ST_WAITL;
							end else if (cls == GAP_LONG) begin
								dec_state = ST_OUT0;
								r.bit_valid = 1'b1;
							end
						end
						ST_WAITL: begin
							dec_state = ST_OUT1;
							r.bit_valid = 1'b1;
							r.bit_value = 1'b1;
						end
						default: begin
							dec_state = ST_OUT0;
							r.bit_valid = 1'b1;
						end
					endcase
				end
			end
		end
		r.bit_period_ms = period;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mtd_result_t want;
		mtd_result_t got;
		if (!arst_n) begin
			dec_state = ST_INITIAL;
			prev_time = '0;
			pre_count = '0;
			first_time = '0;
			period = '0;
			due_results.delete();
			results_seen <= 0;
		end else begin
			// compare before queuing: a result never belongs to an edge of the same cycle
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				got = m_tdata[19:0];
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: result beat with none expected, expected none, got %0h",
						$time, m_tdata);
				end else begin
					want = due_results.pop_front();
					check_field("bit_valid", 16'(want.bit_valid), 16'(got.bit_valid));
					check_field("bit_value", 16'(want.bit_value), 16'(got.bit_value));
					check_field("preamble_done", 16'(want.preamble_done),
						16'(got.preamble_done));
					check_field("pause_reset", 16'(want.pause_reset), 16'(got.pause_reset));
					check_field("bit_period_ms", want.bit_period_ms, got.bit_period_ms);
				end
			end
			if (s_tvalid && s_tready)
				due_results.push_back(decode_edge(s_tdata[31:0], s_tdata[32], s_tdata[33],
					s_tuser));
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the edge-decoder testbench: clock, reset, edge stimulus, watchdog and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mtd_pkg::*;

	// Cycles without any accepted beat before the run is declared hung.
	localparam int QUIET_LIMIT = 5000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	int errors;
	int results_seen;

	// Stimulus bookkeeping: beats sent, enabled edges sent, line clock.
	int          sent       = 0;
	int          active     = 0;
	logic [31:0] now        = '0;
	int unsigned est_period = 0;
	int          src_idle   = 11;
	int          snk_idle   = 61;
	int          quiet      = 0;

	manchester_edge_timing_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mtd_decode_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.errors       (errors),
		.results_seen (results_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result side at the rate of the current phase.
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_idle);

	// Watchdog: count cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Send one edge beat. Called at a rising edge; returns at the edge that takes it.
	// Valid stays high between back-to-back beats and drops only for an idle gap.
	task automatic send_edge(input logic [31:0] t, input logic lvl, input logic en,
			input logic pre);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, en, lvl, t};
		s_tuser  <= pre;
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
		if (en)
			active++;
	endtask

	// Move the line clock forward by gap and send the edge there.
	task automatic advance(input logic [31:0] gap, input logic lvl, input logic en,
			input logic pre);
		now = now + gap;
		send_edge(now, lvl, en, pre);
	endtask

	// Pick a gap whose doubled value lies in [lo2, hi2], favoring both ends.
	function automatic logic [31:0] pick_gap(input longint lo2, input longint hi2);
		longint lo;
		longint hi;
		lo = (lo2 + 1) / 2;
		hi = hi2 / 2;
		if (lo < 0)
			lo = 0;
		if (hi < lo)
			hi = lo;
		case ($urandom_range(0, 3))
			0:       return 32'(lo);
			1:       return 32'(hi);
			default: return 32'(lo + $urandom_range(0, 32'(hi - lo)));
		endcase
	endfunction

	// One frame: optional line noise, a preamble that mostly sets a new period, then data edges
	// whose gaps are drawn from the short / long / very long / pause / reject bands.
	task automatic run_frame();
		int unsigned tgt;
		int unsigned g;
		int unsigned n;
		int unsigned c;
		int unsigned edges;
		int          k;
		logic        lvl;
		longint      p;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				now = $urandom();
				send_edge(now, 1'($urandom()), 1'($urandom()), 1'($urandom()));
			end
		end
		// Preamble spacing g gives a period of g/2; keep 2g above the old period so no
		// preamble edge is rejected. Now and then pick a span that saturates the period.
		c = $urandom_range(0, 19);
		if (c == 0) begin
			g = $urandom_range(32'd1 << 17, 32'd1 << 28);
		end else begin
			tgt = (c == 1) ? $urandom_range(1000, 65535) : $urandom_range(1, 200);
			if (4 * tgt < est_period)
				tgt = est_period / 4 + 1;
			g = 2 * tgt;
		end
		// Mostly a complete preamble; sometimes a broken one or a low first edge.
		edges = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : PREAMBLE_EDGES + 1;
		lvl = ($urandom_range(0, 9) != 0);
		for (k = 0; k < edges; k++) begin
			advance(g, lvl, 1'b1, 1'b1);
			lvl = ~lvl;
		end
		if (edges == PREAMBLE_EDGES + 1)
			est_period = (g / 2 > 65535) ? 65535 : g / 2;
		// Data edges against the estimated period.
		p = est_period;
		n = $urandom_range(4, 40);
		for (k = 0; k < n; k++) begin
			c = $urandom_range(0, 99);
			if (c < 40)
				g = pick_gap(p, 3 * p - 1);
			else if (c < 75)
				g = pick_gap(3 * p, 5 * p);
			else if (c < 85)
				g = pick_gap(5 * p + 1, 25 * p);
			else if (c < 92)
				g = pick_gap(25 * p + 1, 60 * p + 2);
			else
				g = pick_gap(0, p - 1);
			advance(g, lvl, ($urandom_range(0, 19) != 0), ($urandom_range(0, 49) == 0));
			lvl = ~lvl;
		end
	endtask

	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges, period still zero: disabled edge, zero gap, pause on any gap,
		// the widest gap, and a low level that must not open the preamble count.
		now = 32'hFFFF_FFFF;
		send_edge(now, 1'b1, 1'b0, 1'b0);
		now = 32'h0;
		send_edge(now, 1'b1, 1'b1, 1'b0);
		advance(3, 1'b0, 1'b1, 1'b0);
		now = 32'hFFFF_FFFF;
		send_edge(now, 1'b1, 1'b1, 1'b0);
		advance(101, 1'b0, 1'b1, 1'b1);
		// Preamble of spacing 20: period becomes 10.
		for (k = 0; k <= PREAMBLE_EDGES; k++)
			advance(20, ~k[0], 1'b1, 1'b1);
		// Gap bands at P = 10: reject, short at P/2, short just under 1.5P, long at 1.5P,
		// long at exactly 2.5P, very long just over, pause band edges.
		advance(4, 1'b1, 1'b1, 1'b0);
		advance(5, 1'b0, 1'b1, 1'b0);
		advance(5, 1'b1, 1'b1, 1'b0);
		advance(14, 1'b0, 1'b1, 1'b0);
		advance(15, 1'b1, 1'b1, 1'b0);
		advance(5, 1'b0, 1'b1, 1'b0);
		advance(25, 1'b1, 1'b1, 1'b0);
		advance(25, 1'b0, 1'b1, 1'b0);
		advance(26, 1'b1, 1'b1, 1'b0);
		advance(125, 1'b0, 1'b1, 1'b0);
		advance(126, 1'b1, 1'b1, 1'b0);
		advance(7, 1'b0, 1'b0, 1'b1);
		est_period = 10;

		// Random frames in three idling phases; only enabled edges count toward the total.
		k = active;
		while (active - k < 1000) begin
			if (active - k < 333) begin
				src_idle = 11;
				snk_idle = 61;
			end else if (active - k < 666) begin
				src_idle = 61;
				snk_idle = 11;
			end else begin
				src_idle = 0;
				snk_idle = 0;
			end
			run_frame();
		end
		s_tvalid <= 1'b0;

		// Drain: every sent edge owes exactly one result beat.
		while (results_seen != sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
